// ===== sv/set_assoc_lru_writeback_cache_core_assert.svh =====
// Assertion macros for the set-associative write-back cache core
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_CORE_ASSERT_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_CORE_ASSERT_SVH
// same-cycle implication, checked on the clock, off during reset
`define SALWC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cache core check failed");
// next-cycle implication
`define SALWC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cache core check failed");
`endif

// ===== sv/salwc_pkg.sv =====
// Shared types and defaults for the set-associative write-back cache core
`timescale 1ns / 1ps
package salwc_pkg;
   localparam int unsigned DEF_SET_COUNT = 16;
   localparam int unsigned DEF_WAYS      = 4;
   localparam int unsigned DEF_MEM_BYTES = 65536;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_FLUSH = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       hit;
      logic       addr_error;
      logic [6:0] lines_written_back;
   } rsp_type;
endpackage

// ===== sv/salwc_store.sv =====
// Backing store: one 64-bit word per line, zeroed by a sweep after reset
`timescale 1ns / 1ps
module salwc_store
   import salwc_pkg::*;
#(
   parameter int unsigned WORDS = DEF_MEM_BYTES / 8,
   localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_en,
   input  logic          cmd_we,
   input  logic [AW-1:0] cmd_addr,
   input  logic [63:0]   cmd_wdata,
   output logic [63:0]   rdata,
   output logic          ready
);
   logic [63:0]   mem [WORDS];
   logic [AW-1:0] clr_ff, clr_in;
   logic          done_ff, done_in;
   logic [63:0]   rdata_ff;

   always_comb begin
      clr_in  = clr_ff;
      done_in = done_ff;
      if (!done_ff) begin
         if (clr_ff == AW'(WORDS - 1)) begin
            done_in = 1'b1;
         end else begin
            clr_in = clr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         clr_ff  <= clr_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!done_ff) begin
         mem[clr_ff] <= '0;
      end else if (cmd_en && cmd_we) begin
         mem[cmd_addr] <= cmd_wdata;
      end
      if (cmd_en && !cmd_we) begin
         rdata_ff <= mem[cmd_addr];
      end
   end

   assign rdata = rdata_ff;
   assign ready = done_ff;
endmodule

// ===== sv/set_assoc_lru_writeback_cache_core.sv =====
// Hit or clean miss: lookup, then finish; a dirty-victim miss goes through evict and
// fetch between them. Flush reads each set's tags, then walks its ways, adding a
// write-back state for each dirty line.
// Error and unused-kind items give their result in the cycle after accept.
// Reset: tags cleared at once; busy stays high while the backing store sweep zeroes
// every word. Results come on rsp_valid; no stall.
`timescale 1ns / 1ps
`include "set_assoc_lru_writeback_cache_core_assert.svh"
module set_assoc_lru_writeback_cache_core
   import salwc_pkg::*;
#(
   parameter int unsigned SET_COUNT = DEF_SET_COUNT,
   parameter int unsigned WAYS      = DEF_WAYS,
   parameter int unsigned MEM_BYTES = DEF_MEM_BYTES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);
   localparam int unsigned WORDS     = (MEM_BYTES + 7) / 8;
   localparam int unsigned LINE_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned SET_SHIFT = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 0;
   localparam int unsigned SET_W     = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
   localparam int unsigned TAG_W     = (LINE_W > SET_SHIFT) ? LINE_W - SET_SHIFT : 1;
   localparam int unsigned WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned RANK_W    = WAY_W;
   localparam int unsigned NLINES    = SET_COUNT * WAYS;
   localparam int unsigned DIDX_W    = (NLINES > 1) ? $clog2(NLINES) : 1;

   typedef struct packed {
      logic              valid;
      logic              dirty;
      logic [RANK_W-1:0] rank;
      logic [TAG_W-1:0]  tag;
   } way_meta_type;
   typedef way_meta_type [WAYS-1:0] set_meta_type;

   typedef enum logic [8:0] {
      ST_CLEAR   = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_LOOKUP  = 9'b000000100,
      ST_EVICT   = 9'b000001000,
      ST_FETCH   = 9'b000010000,
      ST_FINISH  = 9'b000100000,
      ST_FL_META = 9'b001000000,
      ST_FL_WAY  = 9'b010000000,
      ST_FL_WB   = 9'b100000000
   } state_type;

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [SET_W-1:0] set_ff, set_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [WAY_W-1:0] way_ff, way_in;
   logic          hit_ff, hit_in;
   logic          wasv_ff, wasv_in;
   set_meta_type  meta_ff, meta_in;
   logic [6:0]    wb_ff, wb_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic [SET_COUNT-1:0] setv_ff, setv_in;

   set_meta_type  meta_mem [SET_COUNT];
   set_meta_type  meta_q_ff;
   logic          meta_ok_ff;
   logic          meta_re, meta_we;
   logic [SET_W-1:0] meta_raddr;
   set_meta_type  meta_wdata, meta_eff;

   logic [63:0]   data_mem [NLINES];
   logic [63:0]   data_q_ff;
   logic          data_re, data_we;
   logic [DIDX_W-1:0] data_idx;
   logic [63:0]   data_wdata;

   logic          st_en, st_we, st_ready;
   logic [LINE_W-1:0] st_addr;
   logic [63:0]   st_wdata, st_rdata;

   logic [28:0]   lineno;
   logic          acc, addr_bad;
   logic          hit_any, inv_any;
   logic [WAY_W-1:0] hit_way, inv_way, lru_way, vic_way;
   logic [63:0]   line_src, line_new;
   logic [5:0]    sh;
   set_meta_type  meta_touch, meta_fl;

   function automatic logic [LINE_W-1:0] line_of(input logic [TAG_W-1:0] t,
                                                 input logic [SET_W-1:0] s);
      logic [LINE_W+SET_W+TAG_W-1:0] v;
      v = ((LINE_W+SET_W+TAG_W)'(t) << SET_SHIFT) | (LINE_W+SET_W+TAG_W)'(s);
      return v[LINE_W-1:0];
   endfunction

   function automatic logic [DIDX_W-1:0] didx(input logic [SET_W-1:0] s,
                                              input logic [WAY_W-1:0] w);
      logic [31:0] v;
      v = 32'(s) * 32'(WAYS) + 32'(w);
      return v[DIDX_W-1:0];
   endfunction

   salwc_store #(.WORDS(WORDS)) u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd_en    (st_en),
      .cmd_we    (st_we),
      .cmd_addr  (st_addr),
      .cmd_wdata (st_wdata),
      .rdata     (st_rdata),
      .ready     (st_ready)
   );

   assign acc      = start && (state_ff == ST_IDLE);
   assign lineno   = req_item.address[31:3];
   assign addr_bad = {1'b0, req_item.address} >= 33'(MEM_BYTES);
   assign meta_eff = meta_ok_ff ? meta_q_ff : '0;
   assign sh       = {req_ff.address[2:0], 3'b000};
   assign line_src = hit_ff ? data_q_ff : st_rdata;

   always_comb begin
      hit_any = 1'b0;
      inv_any = 1'b0;
      hit_way = '0;
      inv_way = '0;
      lru_way = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (meta_eff[i].valid && meta_eff[i].tag == tag_ff) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(i);
         end
         if (!meta_eff[i].valid) begin
            inv_any = 1'b1;
            inv_way = WAY_W'(i);
         end
         if (meta_eff[i].rank == RANK_W'(WAYS - 1)) begin
            lru_way = WAY_W'(i);
         end
      end
      vic_way = inv_any ? inv_way : lru_way;
   end

   always_comb begin
      meta_touch = meta_ff;
      for (int i = 0; i < WAYS; i++) begin
         if (WAY_W'(i) != way_ff && meta_ff[i].valid &&
             (!wasv_ff || meta_ff[i].rank < meta_ff[way_ff].rank)) begin
            meta_touch[i].rank = meta_ff[i].rank + RANK_W'(1);
         end
      end
      meta_touch[way_ff].rank  = '0;
      meta_touch[way_ff].valid = 1'b1;
      meta_touch[way_ff].tag   = tag_ff;
      meta_touch[way_ff].dirty = (hit_ff && meta_ff[way_ff].dirty) ||
                                 (req_ff.kind == KIND_WRITE);
      line_new = line_src;
      if (req_ff.kind == KIND_WRITE) begin
         line_new = (line_src & ~(64'hFF << sh)) | (64'(req_ff.write_data) << sh);
      end
      meta_fl = meta_ff;
      if (state_ff == ST_FL_WB) begin
         meta_fl[way_ff].dirty = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      way_in       = way_ff;
      hit_in       = hit_ff;
      wasv_in      = wasv_ff;
      meta_in      = meta_ff;
      wb_in        = wb_ff;
      setv_in      = setv_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      meta_re      = 1'b0;
      meta_raddr   = set_ff;
      meta_we      = 1'b0;
      meta_wdata   = meta_touch;
      data_re      = 1'b0;
      data_we      = 1'b0;
      data_idx     = didx(set_ff, way_ff);
      data_wdata   = line_new;
      st_en        = 1'b0;
      st_we        = 1'b0;
      st_addr      = line_of(tag_ff, set_ff);
      st_wdata     = data_q_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (st_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               wb_in  = '0;
               rsp_in = '0;
               if (req_item.kind == KIND_FLUSH) begin
                  set_in     = '0;
                  way_in     = '0;
                  meta_re    = 1'b1;
                  meta_raddr = '0;
                  state_in   = ST_FL_META;
               end else if (req_item.kind == KIND_NONE) begin
                  rsp_valid_in = 1'b1;
               end else if (addr_bad) begin
                  rsp_in.addr_error = 1'b1;
                  rsp_valid_in      = 1'b1;
               end else begin
                  set_in     = SET_W'(lineno & 29'(SET_COUNT - 1));
                  tag_in     = TAG_W'(lineno >> SET_SHIFT);
                  meta_re    = 1'b1;
                  meta_raddr = SET_W'(lineno & 29'(SET_COUNT - 1));
                  state_in   = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            meta_in = meta_eff;
            hit_in  = hit_any;
            if (hit_any) begin
               way_in   = hit_way;
               wasv_in  = 1'b1;
               data_re  = 1'b1;
               data_idx = didx(set_ff, hit_way);
               state_in = ST_FINISH;
            end else begin
               way_in  = vic_way;
               wasv_in = !inv_any;
               if (!inv_any && meta_eff[vic_way].dirty) begin
                  data_re  = 1'b1;
                  data_idx = didx(set_ff, vic_way);
                  state_in = ST_EVICT;
               end else begin
                  st_en    = 1'b1;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_EVICT: begin
            st_en    = 1'b1;
            st_we    = 1'b1;
            st_addr  = line_of(meta_ff[way_ff].tag, set_ff);
            wb_in    = wb_ff + 7'd1;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            st_en    = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            data_we         = 1'b1;
            meta_we         = 1'b1;
            setv_in[set_ff] = 1'b1;
            rsp_valid_in    = 1'b1;
            rsp_in.hit      = hit_ff;
            rsp_in.lines_written_back = wb_ff;
            rsp_in.read_data = (req_ff.kind == KIND_READ) ? 8'(line_src >> sh) : 8'h00;
            state_in        = ST_IDLE;
         end
         ST_FL_META: begin
            meta_in  = meta_eff;
            state_in = ST_FL_WAY;
         end
         ST_FL_WAY, ST_FL_WB: begin
            if (state_ff == ST_FL_WAY && meta_ff[way_ff].valid && meta_ff[way_ff].dirty) begin
               data_re  = 1'b1;
               state_in = ST_FL_WB;
            end else begin
               if (state_ff == ST_FL_WB) begin
                  st_en   = 1'b1;
                  st_we   = 1'b1;
                  st_addr = line_of(meta_ff[way_ff].tag, set_ff);
                  wb_in   = wb_ff + 7'd1;
                  meta_in = meta_fl;
               end
               state_in = ST_FL_WAY;
               if (way_ff == WAY_W'(WAYS - 1)) begin
                  meta_we    = 1'b1;
                  meta_wdata = meta_fl;
                  way_in     = '0;
                  if (set_ff == SET_W'(SET_COUNT - 1)) begin
                     rsp_valid_in = 1'b1;
                     rsp_in.lines_written_back = wb_in;
                     state_in     = ST_IDLE;
                  end else begin
                     set_in     = set_ff + SET_W'(1);
                     meta_re    = 1'b1;
                     meta_raddr = set_ff + SET_W'(1);
                     state_in   = ST_FL_META;
                  end
               end else begin
                  way_in = way_ff + WAY_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         setv_ff      <= '0;
         meta_ok_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         setv_ff      <= setv_in;
         if (meta_re) begin
            meta_ok_ff <= setv_ff[meta_raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      set_ff  <= set_in;
      tag_ff  <= tag_in;
      way_ff  <= way_in;
      hit_ff  <= hit_in;
      wasv_ff <= wasv_in;
      meta_ff <= meta_in;
      wb_ff   <= wb_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[set_ff] <= meta_wdata;
      end
      if (meta_re) begin
         meta_q_ff <= meta_mem[meta_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_idx] <= data_wdata;
      end
      if (data_re) begin
         data_q_ff <= data_mem[data_idx];
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `SALWC_ASSERT_SAME(a_rsp_in_idle, rsp_valid_ff, state_ff == ST_IDLE)
   `SALWC_ASSERT_NEXT(a_accept_progress, acc, rsp_valid_ff || state_ff != ST_IDLE)
   `SALWC_ASSERT_SAME(a_hit_no_err, rsp_valid_ff && rsp_ff.hit, !rsp_ff.addr_error)
   `SALWC_ASSERT_SAME(a_store_ready, st_en, st_ready)
endmodule

// ===== tb/salwc_checker.sv =====
// Cache checker: predicts each beat's result and compares it with the block's output
`timescale 1ns / 1ps
module salwc_checker
   import salwc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  rsp_type rsp_item,
   output int      fail_count,
   output int      pending
);
   localparam int SETS  = DEF_SET_COUNT;
   localparam int NWAY  = DEF_WAYS;
   localparam int WORDS = DEF_MEM_BYTES / 8;

   logic [8:0]  tag_q   [SETS*NWAY];
   logic        valid_q [SETS*NWAY];
   logic        dirty_q [SETS*NWAY];
   logic [1:0]  rank_q  [SETS*NWAY];
   logic [63:0] bytes_q [SETS*NWAY];
   logic [63:0] store_q [WORDS];
   rsp_type     rsp_fifo[$];

   function automatic int write_back(int idx);
      int lineno;
      if (!valid_q[idx] || !dirty_q[idx]) return 0;
      lineno = int'(tag_q[idx]) * SETS + idx / NWAY;
      store_q[lineno] = bytes_q[idx];
      dirty_q[idx] = 1'b0;
      return 1;
   endfunction

   function automatic void make_recent(int s, int w, bit was_valid);
      int base;
      base = s * NWAY;
      for (int i = 0; i < NWAY; i++)
         if (i != w && valid_q[base+i] && (!was_valid || rank_q[base+i] < rank_q[base+w]))
            rank_q[base+i]++;
      rank_q[base+w] = '0;
   endfunction

   function automatic rsp_type cache_access(req_type rq);
      rsp_type r;
      int lineno, s, base, way, sh;
      logic [8:0] t;
      bit was_valid;
      logic [1:0] best;
      r = '0;
      if (rq.kind == KIND_FLUSH) begin
         for (int i = 0; i < SETS*NWAY; i++)
            r.lines_written_back = r.lines_written_back + 7'(write_back(i));
      end else if (rq.kind == KIND_READ || rq.kind == KIND_WRITE) begin
         if (rq.address >= DEF_MEM_BYTES) begin
            r.addr_error = 1'b1;
         end else begin
            lineno = int'(rq.address >> 3);
            sh = int'(rq.address[2:0]) * 8;
            s = lineno % SETS;
            t = 9'(lineno / SETS);
            base = s * NWAY;
            way = NWAY;
            for (int w = 0; w < NWAY; w++)
               if (way == NWAY && valid_q[base+w] && tag_q[base+w] == t) way = w;
            if (way < NWAY) begin
               r.hit = 1'b1;
               make_recent(s, way, 1'b1);
            end else begin
               was_valid = 1'b1;
               for (int w = 0; w < NWAY; w++)
                  if (way == NWAY && !valid_q[base+w]) begin
                     way = w;
                     was_valid = 1'b0;
                  end
               if (way == NWAY) begin
                  best = '0;
                  way = 0;
                  for (int w = 0; w < NWAY; w++)
                     if (rank_q[base+w] > best) begin
                        best = rank_q[base+w];
                        way = w;
                     end
                  r.lines_written_back = r.lines_written_back + 7'(write_back(base + way));
               end
               make_recent(s, way, was_valid);
               bytes_q[base+way] = store_q[lineno];
               tag_q[base+way] = t;
               valid_q[base+way] = 1'b1;
               dirty_q[base+way] = 1'b0;
            end
            if (rq.kind == KIND_READ) begin
               r.read_data = bytes_q[base+way][sh +: 8];
            end else begin
               bytes_q[base+way][sh +: 8] = rq.write_data;
               dirty_q[base+way] = 1'b1;
            end
         end
      end
      return r;
   endfunction

   initial begin
      fail_count = 0;
      for (int i = 0; i < SETS*NWAY; i++) begin
         tag_q[i] = '0; valid_q[i] = 0; dirty_q[i] = 0; rank_q[i] = '0; bytes_q[i] = '0;
      end
      for (int i = 0; i < WORDS; i++) store_q[i] = '0;
   end

   assign pending = rsp_fifo.size();

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset) begin
         if (rsp_valid) begin
            if (rsp_fifo.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count++;
            end else begin
               exp_rsp = rsp_fifo.pop_front();
               if (rsp_item.read_data !== exp_rsp.read_data) begin
                  $error("read_data expected %0h actual %0h", exp_rsp.read_data,
                         rsp_item.read_data);
                  fail_count++;
               end
               if (rsp_item.hit !== exp_rsp.hit) begin
                  $error("hit expected %0b actual %0b", exp_rsp.hit, rsp_item.hit);
                  fail_count++;
               end
               if (rsp_item.addr_error !== exp_rsp.addr_error) begin
                  $error("addr_error expected %0b actual %0b", exp_rsp.addr_error,
                         rsp_item.addr_error);
                  fail_count++;
               end
               if (rsp_item.lines_written_back !== exp_rsp.lines_written_back) begin
                  $error("lines_written_back expected %0d actual %0d",
                         exp_rsp.lines_written_back, rsp_item.lines_written_back);
                  fail_count++;
               end
            end
         end
         if (start && !busy) rsp_fifo.push_back(cache_access(req_item));
      end
   end
endmodule

// ===== tb/set_assoc_lru_writeback_cache_core_tb.sv =====
// Testbench top for the cache core: stimulus, reset, timeout and verdict
`timescale 1ns / 1ps
module set_assoc_lru_writeback_cache_core_tb;
   import salwc_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   logic    rsp_valid;
   req_type req_item;
   rsp_type rsp_item;
   int      fail_count;
   int      pending;
   int      burst_left;
   logic [31:0] hot_base;

   set_assoc_lru_writeback_cache_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   salwc_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Verification failed");
      $finish;
   end

   // one beat; holds start through busy, random gaps between bursts
   task automatic send_beat(logic [1:0] k, logic [31:0] a, logic [7:0] d);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      end else begin
         burst_left--;
      end
      start <= 1'b1;
      req_item <= '{kind: k, address: a, write_data: d};
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // addresses mostly in a few hot sets so victims and LRU order get exercised
   function automatic logic [31:0] pick_address();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return hot_base + ($urandom_range(0, 11) << 7) + $urandom_range(0, 7)
                          + ($urandom_range(0, 1) << 3);
      if (r < 90) return $urandom_range(0, DEF_MEM_BYTES - 1);
      if (r < 95) return DEF_MEM_BYTES + $urandom_range(0, 255);
      return $urandom();
   endfunction

   initial begin
      int k;
      start = 1'b0;
      req_item = '0;
      burst_left = 0;
      hot_base = '0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_beat(KIND_READ, 32'd0, 8'h00);
      send_beat(KIND_WRITE, 32'd7, 8'hff);
      send_beat(KIND_READ, 32'd7, 8'h00);
      send_beat(KIND_WRITE, DEF_MEM_BYTES - 1, 8'h5a);
      send_beat(KIND_READ, DEF_MEM_BYTES - 1, 8'h00);
      send_beat(KIND_READ, DEF_MEM_BYTES, 8'h00);
      send_beat(KIND_WRITE, 32'hffff_ffff, 8'hff);
      send_beat(KIND_NONE, 32'h0000_1234, 8'h12);
      // five lines in set 0: evicts the dirty LRU line
      for (int i = 0; i < 5; i++) send_beat(KIND_WRITE, 32'(i << 7), 8'(32'ha5 ^ i));
      send_beat(KIND_READ, 32'd0, 8'h00);
      send_beat(KIND_READ, 32'h0000_0080, 8'h00);
      send_beat(KIND_FLUSH, 32'hffff_ffff, 8'h00);
      send_beat(KIND_FLUSH, 32'd0, 8'h00);
      send_beat(KIND_READ, 32'd0, 8'h00);
      // dirty every line, then flush the lot
      for (int i = 0; i < 64; i++) send_beat(KIND_WRITE, 32'(i << 3), i[7:0]);
      send_beat(KIND_FLUSH, 32'd0, 8'h00);

      for (int n = 0; n < 1250; n++) begin
         if (n % 200 == 100) begin
            start <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
         if (n % 50 == 0) hot_base = $urandom_range(0, 15) << 3;
         k = $urandom_range(0, 99);
         if (k < 45) send_beat(KIND_READ, pick_address(), 8'($urandom()));
         else if (k < 93) send_beat(KIND_WRITE, pick_address(), 8'($urandom()));
         else if (k < 97) send_beat(KIND_FLUSH, $urandom(), 8'($urandom()));
         else send_beat(KIND_NONE, $urandom(), 8'($urandom()));
      end
      start <= 1'b0;
      wait (pending == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+sv
sv/salwc_pkg.sv
sv/salwc_store.sv
sv/set_assoc_lru_writeback_cache_core.sv
tb/salwc_checker.sv
tb/set_assoc_lru_writeback_cache_core_tb.sv
